// File: rtl/bpct_pkg.sv
// bpct_pkg: shared constants, sequencer state type and sine table math
// for the BPSK carrier phase tracker. No dependencies.
`default_nettype none
package bpct_pkg;

    localparam int SPS_DEFAULT        = 16;
    localparam int SINE_SIZE_DEFAULT  = 1024;

    // Q3.13 radians
    localparam int PI_Q13        = 25736;
    localparam int TWO_PI_Q13    = 51472;
    localparam int ONE_RAD_Q13   = 8192;
    localparam int WRAP_HIGH_Q13 = 59664;

    localparam logic [15:0] GAIN_RESET  = 16'd26214;
    localparam logic [13:0] PROBE_RESET = 14'd819;
    localparam logic [15:0] PHASE_RESET = 16'd25736;

    // register indexes
    localparam logic [0:0] REG_LOOP_GAIN    = 1'b0;
    localparam logic [0:0] REG_PROBE_OFFSET = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ANGLE,
        ST_REDUCE,
        ST_RECIP,
        ST_INDEX,
        ST_MAC,
        ST_ACC,
        ST_NUM_LO,
        ST_NUM_HI,
        ST_NUM_SUM,
        ST_DIV_CHECK,
        ST_DIVIDE,
        ST_UPDATE,
        ST_DONE
    } bpct_state_t;

    // sin(pi/2 * u), u in Q30; odd polynomial, Horner in Q30; result Q15.
    // Elaboration use only.
    function automatic longint quarter_sine(input longint u);
        longint u2;
        longint t;
        longint s;
        u2 = (u * u) >>> 30;
        t  = 64'sd172271;
        t  = 64'sd5026937    - ((u2 * t) >>> 30);
        t  = 64'sd85569278   - ((u2 * t) >>> 30);
        t  = 64'sd693598673  - ((u2 * t) >>> 30);
        t  = 64'sd1686629713 - ((u2 * t) >>> 30);
        s  = (u * t) >>> 30;
        s  = (s + 64'sd16384) >>> 15;
        if (s > 64'sd32767) s = 64'sd32767;
        if (s < 64'sd0) s = 64'sd0;
        return s;
    endfunction

endpackage
`default_nettype wire

// File: rtl/bpsk_carrier_phase_tracker_core.sv
// bpsk_carrier_phase_tracker_core: early/late correlation phase tracker.
// Depends on bpct_pkg (constants, state enum, quarter-wave sine math).
//
// Channel   Signals                                  Width      Dir
// sample    sample_valid/sample_ready, sample        16 signed  in
// result    result_valid/result_ready, phase,        16 + 1     out
//           phase_updated
// config    cfg_we, cfg_index, cfg_data              1/1/16     in
//
// An item that does not close a symbol is taken and its result lands in the
// output register at the same edge. An item that closes a symbol starts the
// sequencer: per symbol sample it loads the sample, then for the early and
// the late probe it forms the angle, reduces it (up to three subtracts),
// takes the reciprocal product and looks up the sine, then multiplies and
// accumulates. Next come the gain product and a 16-step restoring divide,
// skipped when the quotient saturates. No new item is taken while the
// sequencer runs, kept serial by the single shared multiplier and divide loop.
// Reset clears control and config; the sample buffer needs no clearing.
// A result still waiting on result_ready holds off the next item.
`default_nettype none
module bpsk_carrier_phase_tracker_core
    import bpct_pkg::*;
#(
    parameter int SAMPLES_PER_SYMBOL = SPS_DEFAULT,      // 4 .. 64
    parameter int SINE_TABLE_SIZE    = SINE_SIZE_DEFAULT // power of two, 64 .. 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_ready,
    input  wire logic signed [15:0] sample,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic [15:0]             phase,
    output logic                    phase_updated,
    input  wire logic               cfg_we,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    localparam int SPS   = SAMPLES_PER_SYMBOL;
    localparam int PW    = $clog2(SPS);
    localparam int IW    = $clog2(SINE_TABLE_SIZE);
    localparam int N4    = SINE_TABLE_SIZE / 4;
    localparam int QTAB_DEPTH = N4 + 1;
    // angle*N/16 stays below 3217*N; exact reciprocal of 3217
    localparam int YW    = IW + 12;
    localparam longint RECIP_M = ((64'sd1 <<< (YW + 12)) + 64'sd3216) / 64'sd3217;
    localparam int ACCW  = 33 + PW;
    localparam int MAGW  = 32 + PW;
    localparam int LO    = (MAGW + 1) / 2;
    localparam int HI    = MAGW - LO;
    localparam int NSUMW = MAGW + 17;
    localparam int NSHW  = NSUMW - 18;
    localparam int MULW  = (YW + 2 > LO + 1) ? YW + 2 : LO + 1;
    localparam int PRODW = 2 * MULW;

    typedef logic [14:0] qtab_t [QTAB_DEPTH];
    typedef logic [15:0] base_t [SPS];

    function automatic qtab_t build_qtab();
        qtab_t  t;
        longint u;
        for (int m = 0; m < QTAB_DEPTH; m++)
        begin
            u    = longint'(m) <<< (30 - (IW - 2));
            t[m] = 15'(quarter_sine(u));
        end
        return t;
    endfunction

    function automatic base_t build_base();
        base_t b;
        for (int i = 0; i < SPS; i++)
        begin
            b[i] = 16'((longint'(i) * TWO_PI_Q13 + SPS / 2) / SPS);
        end
        return b;
    endfunction

    localparam qtab_t QTAB = build_qtab();
    localparam base_t BASE = build_base();

    bpct_state_t state_reg, state_next;

    logic [15:0]             gain_reg;
    logic [13:0]             probe_reg;
    logic [15:0]             phase_reg;
    logic [PW-1:0]           pos_reg;
    logic [PW-1:0]           sym_idx_reg;
    logic                    late_reg;
    logic [17:0]             ang_reg;
    logic signed [PRODW-1:0] prod_reg;
    logic signed [15:0]      se_reg;
    logic signed [15:0]      sl_reg;
    logic signed [ACCW-1:0]  acc_reg;
    logic [14:0]             peak_reg;
    logic [NSUMW-1:0]        lo_reg;
    logic [NSHW-1:0]         nsh_reg;
    logic [30:0]             rem_reg;
    logic [15:0]             quo_reg;
    logic [3:0]              bit_reg;
    logic                    res_valid_reg;
    logic [15:0]             res_phase_reg;
    logic                    res_upd_reg;
    logic signed [15:0]      x_reg;

    logic signed [15:0] sym_mem [SPS];

    // handshake and control
    logic take;
    logic out_free;
    logic sym_end;
    logic mem_we;
    logic res_load;

    // shared multiplier
    logic signed [MULW-1:0]  mul_a;
    logic signed [MULW-1:0]  mul_b;
    logic signed [PRODW-1:0] mul_p;

    // datapath helpers
    logic [IW+16:0]          y_full;
    logic [YW-1:0]           y_val;
    logic [IW:0]             idx_raw;
    logic [IW-1:0]           idx_w;
    logic [IW-2:0]           q_idx;
    logic [14:0]             q_val;
    logic signed [15:0]      sine_val;
    logic signed [16:0]      sdiff;
    logic [MAGW-1:0]         acc_mag;
    logic [NSUMW-1:0]        num_sum;
    logic [30:0]             peak_sh;
    logic [15:0]             mag;
    logic signed [17:0]      corr;
    logic signed [17:0]      ph_sum;
    logic signed [17:0]      ph_wrap;

    assign out_free = !res_valid_reg || result_ready;
    assign take     = sample_valid && sample_ready;
    assign sym_end  = (pos_reg == PW'(SPS - 1));
    // output register loads: short item at intake, or the closing item at the end
    assign res_load = (take && !sym_end) || ((state_reg == ST_DONE) && out_free);

    assign result_valid  = res_valid_reg;
    assign phase         = res_phase_reg;
    assign phase_updated = res_upd_reg;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (take && sym_end) state_next = ST_LOAD;
            ST_LOAD:      state_next = ST_ANGLE;
            ST_ANGLE:     state_next = ST_REDUCE;
            ST_REDUCE:    if (ang_reg < 18'(TWO_PI_Q13)) state_next = ST_RECIP;
            ST_RECIP:     state_next = ST_INDEX;
            ST_INDEX:     state_next = late_reg ? ST_MAC : ST_ANGLE;
            ST_MAC:       state_next = ST_ACC;
            ST_ACC:       state_next = (sym_idx_reg == PW'(SPS - 1)) ? ST_NUM_LO : ST_LOAD;
            ST_NUM_LO:    state_next = ST_NUM_HI;
            ST_NUM_HI:    state_next = ST_NUM_SUM;
            ST_NUM_SUM:   state_next = ST_DIV_CHECK;
            ST_DIV_CHECK:
            begin
                if (nsh_reg >= NSHW'({peak_reg, 16'd0})) state_next = ST_UPDATE;
                else state_next = ST_DIVIDE;
            end
            ST_DIVIDE:    if (bit_reg == 4'd0) state_next = ST_UPDATE;
            ST_UPDATE:    state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb
    begin
        sample_ready = 1'b0;
        mem_we       = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = out_free;
                mem_we       = sample_valid && out_free;
            end
            ST_RECIP:
            begin
                mul_a = MULW'(signed'({1'b0, y_val}));
                mul_b = MULW'(RECIP_M);
            end
            ST_MAC:
            begin
                mul_a = MULW'(x_reg);
                mul_b = MULW'(sdiff);
            end
            ST_NUM_LO:
            begin
                mul_a = MULW'(signed'({1'b0, acc_mag[LO-1:0]}));
                mul_b = MULW'(signed'({1'b0, gain_reg}));
            end
            ST_NUM_HI:
            begin
                mul_a = MULW'(signed'({1'b0, acc_mag[MAGW-1:LO]}));
                mul_b = MULW'(signed'({1'b0, gain_reg}));
            end
            default:
            begin
                sample_ready = 1'b0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // angle -> table index: floor((a*N + pi) / 2pi) as a multiply by 1/3217
    assign y_full  = {1'b0, ang_reg[15:0], {IW{1'b0}}} + (IW+17)'(PI_Q13);
    assign y_val   = y_full[YW+3:4];
    assign idx_raw = prod_reg[YW+12 +: IW+1];
    assign idx_w   = idx_raw[IW] ? '0 : idx_raw[IW-1:0];
    assign q_idx   = idx_w[IW-2] ? ((IW-1)'(N4) - (IW-1)'(idx_w[IW-3:0]))
                                 : (IW-1)'(idx_w[IW-3:0]);
    assign q_val   = QTAB[q_idx];
    assign sine_val = idx_w[IW-1] ? -signed'({1'b0, q_val}) : signed'({1'b0, q_val});
    assign sdiff   = 17'(sl_reg) - 17'(se_reg);

    assign acc_mag = acc_reg[ACCW-1] ? MAGW'(-acc_reg) : MAGW'(acc_reg);
    // |num| + den/2, already carries the rounding term
    assign num_sum = (NSUMW'(prod_reg[HI+15:0]) << LO) + lo_reg
                   + NSUMW'({peak_reg, 17'd0});
    assign peak_sh = 31'({peak_reg, 15'd0}) >> (4'd15 - bit_reg);

    assign mag     = (quo_reg > 16'(PI_Q13)) ? 16'(PI_Q13) : quo_reg;
    assign corr    = acc_reg[ACCW-1] ? -signed'({2'b0, mag}) : signed'({2'b0, mag});
    assign ph_sum  = signed'({2'b0, phase_reg}) + corr;

    always_comb
    begin
        if (ph_sum < 18'sd8192)
            ph_wrap = ph_sum + 18'sd51472;
        else if (ph_sum > 18'sd59664)
            ph_wrap = ph_sum - 18'sd51472;
        else
            ph_wrap = ph_sum;
    end

    // symbol buffer, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            sym_mem[pos_reg] <= sample;
        x_reg <= sym_mem[sym_idx_reg];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gain_reg      <= GAIN_RESET;
            probe_reg     <= PROBE_RESET;
            phase_reg     <= PHASE_RESET;
            pos_reg       <= '0;
            sym_idx_reg   <= '0;
            late_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LOOP_GAIN:    gain_reg  <= cfg_data;
                    REG_PROBE_OFFSET: probe_reg <= cfg_data[13:0];
                    default:          gain_reg  <= gain_reg;
                endcase
            end
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && result_ready)
                res_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        if (sym_end)
                        begin
                            pos_reg     <= '0;
                            sym_idx_reg <= '0;
                            late_reg    <= 1'b0;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + 1'b1;
                        end
                    end
                end
                ST_INDEX: late_reg <= 1'b1;
                ST_ACC:
                begin
                    late_reg <= 1'b0;
                    if (sym_idx_reg != PW'(SPS - 1))
                        sym_idx_reg <= sym_idx_reg + 1'b1;
                end
                ST_UPDATE: phase_reg <= ph_wrap[15:0];
                default:   late_reg <= late_reg;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (state_reg)
            ST_IDLE:
            begin
                acc_reg  <= '0;
                peak_reg <= 15'd1;
                if (res_load)
                begin
                    res_phase_reg <= phase_reg;
                    res_upd_reg   <= 1'b0;
                end
            end
            ST_ANGLE:
                ang_reg <= 18'(BASE[sym_idx_reg]) + 18'(phase_reg)
                         + (late_reg ? 18'(probe_reg)
                                     : (18'(TWO_PI_Q13) - 18'(probe_reg)));
            ST_REDUCE:
                if (ang_reg >= 18'(TWO_PI_Q13))
                    ang_reg <= ang_reg - 18'(TWO_PI_Q13);
            ST_INDEX:
                if (late_reg) sl_reg <= sine_val;
                else          se_reg <= sine_val;
            ST_ACC:
            begin
                acc_reg <= acc_reg + prod_reg[ACCW-1:0];
                if (x_reg > signed'({1'b0, peak_reg}))
                    peak_reg <= x_reg[14:0];
            end
            ST_NUM_HI:  lo_reg  <= NSUMW'(prod_reg[LO+15:0]);
            ST_NUM_SUM: nsh_reg <= num_sum[NSUMW-1:18];
            ST_DIV_CHECK:
            begin
                rem_reg <= nsh_reg[30:0];
                quo_reg <= (nsh_reg >= NSHW'({peak_reg, 16'd0})) ? 16'(PI_Q13) : 16'd0;
                bit_reg <= 4'd15;
            end
            ST_DIVIDE:
            begin
                if (rem_reg >= peak_sh)
                begin
                    rem_reg <= rem_reg - peak_sh;
                    quo_reg <= quo_reg | (16'd1 << bit_reg);
                end
                bit_reg <= bit_reg - 1'b1;
            end
            ST_DONE:
            begin
                if (res_load)
                begin
                    res_phase_reg <= phase_reg;
                    res_upd_reg   <= 1'b1;
                end
            end
            default: ang_reg <= ang_reg;
        endcase
    end

endmodule
`default_nettype wire
